// ----- rtl/group_reverse_stream_assert.svh -----
// ----------------------------------------------------------------------------
// group_reverse_stream assertion macros
// property shorthands used by the checker file of the block
// ----------------------------------------------------------------------------
`ifndef GROUP_REVERSE_STREAM_ASSERT_SVH
`define GROUP_REVERSE_STREAM_ASSERT_SVH

// same-cycle implication, dis switches the check off while high
`define GRS_ASSERT_IMPL(label, clk, dis, a, b) \
    label: assert property (@(posedge clk) disable iff (dis) (a) |-> (b)) \
        else $error("assertion failed");

// next-cycle implication, dis switches the check off while high
`define GRS_ASSERT_NEXT(label, clk, dis, a, b) \
    label: assert property (@(posedge clk) disable iff (dis) (a) |=> (b)) \
        else $error("assertion failed");

`endif

// ----- rtl/grs_pkg.sv -----
// ----------------------------------------------------------------------------
// grs_pkg
// types and fixed widths shared by the group reverse stream block
// ----------------------------------------------------------------------------
package grs_pkg;

    localparam int DATA_W  = 32;
    localparam int GSIZE_W = 5;

    typedef struct packed {
        logic signed [DATA_W-1:0] value;
        logic                     end_of_sequence;
    } t_in_item;

    typedef struct packed {
        logic signed [DATA_W-1:0] out_value;
        logic                     out_last;
    } t_out_item;

    // move requests for the row of cells
    typedef struct packed {
        logic shift_right;
        logic shift_left;
    } t_cell_ctl;

    // controller to datapath
    typedef struct packed {
        t_cell_ctl row;
        logic      emit;
        logic      emit_tail;
        logic      emit_last;
    } t_grs_ctl;

endpackage

// ----- rtl/grs_cell.sv -----
// ----------------------------------------------------------------------------
// grs_cell
// one element of the group store, moves towards either neighbour
// ----------------------------------------------------------------------------
module grs_cell (
    input  logic                              i_clk,
    input  grs_pkg::t_cell_ctl                i_ctl,
    input  logic signed [grs_pkg::DATA_W-1:0] i_prev,
    input  logic signed [grs_pkg::DATA_W-1:0] i_next,
    output logic signed [grs_pkg::DATA_W-1:0] o_data
);

    logic signed [grs_pkg::DATA_W-1:0] r_data;
    logic signed [grs_pkg::DATA_W-1:0] n_data;

    always_comb begin
        if (i_ctl.shift_right) begin
            n_data = i_prev;
        end else if (i_ctl.shift_left) begin
            n_data = i_next;
        end else begin
            n_data = r_data;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;

endmodule

// ----- rtl/grs_ctrl.sv -----
// ----------------------------------------------------------------------------
// grs_ctrl
// fill, align and drain sequencing for the row of cells
// ----------------------------------------------------------------------------
module grs_ctrl #(
    parameter int MAX_GROUP = 16,
    parameter int CW        = $clog2(MAX_GROUP + 1)
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_fire,
    input  logic              i_eos,
    input  logic [CW-1:0]     i_k,
    input  logic              i_slot_free,
    output logic              o_in_ready,
    output grs_pkg::t_grs_ctl o_ctl
);

    typedef enum logic [3:0] {
        S_FILL  = 4'b0001,
        S_POP   = 4'b0010,
        S_ALIGN = 4'b0100,
        S_FIFO  = 4'b1000
    } t_state;

    t_state        r_state, n_state;
    logic [CW-1:0] r_fill, n_fill;
    logic [CW-1:0] r_rem, n_rem;
    logic [CW-1:0] r_align, n_align;
    logic          r_last, n_last;
    logic [CW-1:0] w_n;
    logic [CW-1:0] w_gap;

    assign w_n   = r_fill + CW'(1);
    assign w_gap = CW'(MAX_GROUP) - w_n;

    always_comb begin
        n_state = r_state;
        n_fill  = r_fill;
        n_rem   = r_rem;
        n_align = r_align;
        n_last  = r_last;
        o_ctl   = '0;
        unique case (r_state)
            S_FILL: begin
                if (i_in_fire) begin
                    o_ctl.row.shift_right = 1'b1;
                    if (w_n >= i_k) begin
                        n_state = S_POP;
                        n_rem   = w_n;
                        n_fill  = '0;
                        n_last  = i_eos;
                    end else if (i_eos) begin
                        // partial group: walk the oldest beat to the tail cell
                        n_rem   = w_n;
                        n_fill  = '0;
                        n_last  = 1'b1;
                        n_align = w_gap;
                        n_state = (w_gap != '0) ? S_ALIGN : S_FIFO;
                    end else begin
                        n_fill = w_n;
                    end
                end
            end
            S_POP: begin
                if (i_slot_free) begin
                    o_ctl.emit           = 1'b1;
                    o_ctl.row.shift_left = 1'b1;
                    o_ctl.emit_last      = r_last && (r_rem == CW'(1));
                    n_rem                = r_rem - CW'(1);
                    if (r_rem == CW'(1)) begin
                        n_state = S_FILL;
                    end
                end
            end
            S_ALIGN: begin
                o_ctl.row.shift_right = 1'b1;
                n_align               = r_align - CW'(1);
                if (r_align == CW'(1)) begin
                    n_state = S_FIFO;
                end
            end
            S_FIFO: begin
                if (i_slot_free) begin
                    o_ctl.emit            = 1'b1;
                    o_ctl.emit_tail       = 1'b1;
                    o_ctl.row.shift_right = 1'b1;
                    o_ctl.emit_last       = r_last && (r_rem == CW'(1));
                    n_rem                 = r_rem - CW'(1);
                    if (r_rem == CW'(1)) begin
                        n_state = S_FILL;
                    end
                end
            end
            default: begin
                n_state = S_FILL;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_FILL;
            r_fill  <= '0;
            r_rem   <= '0;
            r_align <= '0;
            r_last  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_fill  <= n_fill;
            r_rem   <= n_rem;
            r_align <= n_align;
            r_last  <= n_last;
        end
    end

    assign o_in_ready = (r_state == S_FILL);

endmodule

// ----- rtl/group_reverse_stream.sv -----
// ----------------------------------------------------------------------------
// group_reverse_stream
// reverses a stream of signed words in groups of the configured size; a trailing partial group leaves in arrival order
// drain: after the last input beat of a full group the controller pops it newest
//   first from the head cell; a trailing partial group is first shifted to the tail cell
// flow: no input is taken while a group drains, as the single row of cells
//   either fills or drains; the drain waits on a free output slot
// reset: synchronous, active low; group size returns to 1, fill count to 0
// ----------------------------------------------------------------------------
module group_reverse_stream #(
    parameter int MAX_GROUP = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  grs_pkg::t_in_item            i_in,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output grs_pkg::t_out_item           o_out,
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [grs_pkg::GSIZE_W-1:0]  i_cfg_data
);

    localparam int CW = $clog2(MAX_GROUP + 1);
    localparam int KW = (CW > grs_pkg::GSIZE_W) ? CW : grs_pkg::GSIZE_W;

    logic [grs_pkg::GSIZE_W-1:0]       r_group_size;
    logic [KW-1:0]                     w_gs_ext;
    logic [CW-1:0]                     w_k;
    logic                              w_in_fire;
    logic                              w_slot_free;
    grs_pkg::t_grs_ctl                 w_ctl;
    logic signed [grs_pkg::DATA_W-1:0] w_data [MAX_GROUP];
    logic                              r_ovalid, n_ovalid;
    grs_pkg::t_out_item                r_out;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_group_size <= grs_pkg::GSIZE_W'(1);
        end else if (i_cfg_valid) begin
            r_group_size <= i_cfg_data;
        end
    end

    // zero behaves as one, anything above the row length saturates
    assign w_gs_ext = KW'(r_group_size);
    always_comb begin
        if (r_group_size == '0) begin
            w_k = CW'(1);
        end else if (w_gs_ext > KW'(MAX_GROUP)) begin
            w_k = CW'(MAX_GROUP);
        end else begin
            w_k = CW'(w_gs_ext);
        end
    end

    assign w_in_fire   = i_in_valid && o_in_ready;
    assign w_slot_free = !r_ovalid || i_out_ready;

    grs_ctrl #(
        .MAX_GROUP (MAX_GROUP),
        .CW        (CW)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_fire   (w_in_fire),
        .i_eos       (i_in.end_of_sequence),
        .i_k         (w_k),
        .i_slot_free (w_slot_free),
        .o_in_ready  (o_in_ready),
        .o_ctl       (w_ctl)
    );

    // cell 0 is the head, new beats enter there
    for (genvar g = 0; g < MAX_GROUP; g++) begin : g_cell
        logic signed [grs_pkg::DATA_W-1:0] w_prev;
        logic signed [grs_pkg::DATA_W-1:0] w_next;
        if (g == 0) begin : g_head
            assign w_prev = i_in.value;
        end else begin : g_body
            assign w_prev = w_data[g-1];
        end
        if (g == MAX_GROUP - 1) begin : g_tail
            assign w_next = w_data[g];
        end else begin : g_mid
            assign w_next = w_data[g+1];
        end
        grs_cell u_cell (
            .i_clk  (i_clk),
            .i_ctl  (w_ctl.row),
            .i_prev (w_prev),
            .i_next (w_next),
            .o_data (w_data[g])
        );
    end

    always_comb begin
        if (w_ctl.emit) begin
            n_ovalid = 1'b1;
        end else if (i_out_ready) begin
            n_ovalid = 1'b0;
        end else begin
            n_ovalid = r_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else begin
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ctl.emit) begin
            r_out.out_value <= w_ctl.emit_tail ? w_data[MAX_GROUP-1] : w_data[0];
            r_out.out_last  <= w_ctl.emit_last;
        end
    end

    assign o_out_valid = r_ovalid;
    assign o_out       = r_out;

endmodule

// ----- rtl/grs_checker.sv -----
// ----------------------------------------------------------------------------
// grs_checker
// port level checks on the group reverse stream, bound to the top level
// ----------------------------------------------------------------------------
`include "group_reverse_stream_assert.svh"

module grs_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_in_valid,
    input logic                        o_in_ready,
    input grs_pkg::t_in_item           i_in,
    input logic                        o_out_valid,
    input logic                        i_out_ready,
    input grs_pkg::t_out_item          o_out
);

    logic w_in_beat;
    logic w_out_stall;
    logic w_idle;

    assign w_in_beat   = i_in_valid && o_in_ready;
    assign w_out_stall = o_out_valid && !i_out_ready;
    assign w_idle      = o_in_ready && !w_in_beat && !o_out_valid;

    // a stalled result beat holds
    `GRS_ASSERT_NEXT(a_out_hold, i_clk, !i_rst_n, w_out_stall, o_out_valid && $stable(o_out))

    // the final beat of a sequence always starts a drain
    `GRS_ASSERT_NEXT(a_eos_drains, i_clk, !i_rst_n, w_in_beat && i_in.end_of_sequence, !o_in_ready)

    // while filling with nothing accepted no result beat appears
    `GRS_ASSERT_NEXT(a_no_spurious, i_clk, !i_rst_n, w_idle, !o_out_valid)

    // reset empties the result side
    `GRS_ASSERT_NEXT(a_reset_empty, i_clk, 1'b0, !i_rst_n, !o_out_valid && o_in_ready)

endmodule

bind group_reverse_stream grs_checker u_grs_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .i_in        (i_in),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out       (o_out)
);
